>>> rtl/core/ssc_pkg.sv
// Shared types, codes and constants of the stream session controller.
package ssc_pkg;

    // Width of the millisecond time base and the CRC.
    localparam int TIME_W = 32;
    localparam int CRC_W  = 32;
    localparam int SEQ_W  = 16;
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;

    // Command line buffer capacity in bytes, counting the terminator slot.
    localparam int LINE_CAPACITY = 32;
    localparam int LINE_W        = $clog2(LINE_CAPACITY);

    // Item kinds.
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Special received bytes.
    localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_NULL = 8'h00;

    // Command table: bit 0 is ON, bit 1 is PING, bit 2 is OFF.
    localparam int CMD_COUNT   = 3;
    localparam int CMD_MAX_LEN = 14;
    localparam int CMD_POS_W   = $clog2(CMD_MAX_LEN);
    localparam int CMD_ON      = 0;
    localparam int CMD_PING    = 1;
    localparam int CMD_OFF     = 2;

    localparam logic [LINE_W-1:0] CMD_LEN [CMD_COUNT] = '{
        LINE_W'(12), LINE_W'(14), LINE_W'(13)
    };

    // Each command shares a ten-character prefix followed by its keyword.
    localparam logic [BYTE_W-1:0] CMD_TEXT [CMD_COUNT][CMD_MAX_LEN] = '{
        '{8'h46, 8'h4D, 8'h4A, 8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h20,
          8'h4F, 8'h4E, 8'h00, 8'h00},
        '{8'h46, 8'h4D, 8'h4A, 8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h20,
          8'h50, 8'h49, 8'h4E, 8'h47},
        '{8'h46, 8'h4D, 8'h4A, 8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h20,
          8'h4F, 8'h46, 8'h46, 8'h00}
    };

    // Operations handed from the front end to the session engine.
    localparam logic [1:0] OP_ON   = 2'd0;
    localparam logic [1:0] OP_PING = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    // Result event codes.
    localparam logic [1:0] EV_READY   = 2'd0;
    localparam logic [1:0] EV_STOPPED = 2'd1;
    localparam logic [1:0] EV_FRAME   = 2'd2;

    // Configuration register map.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CLIENT_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FRAME_PERIOD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FRAME_BYTES    = 2'd2;

    localparam logic [TIME_W-1:0] CFG_CLIENT_TIMEOUT_RST = 32'd3000;
    localparam logic [TIME_W-1:0] CFG_FRAME_PERIOD_RST   = 32'd100;
    localparam logic [LEN_W-1:0]  CFG_FRAME_BYTES_RST    = 16'd64800;

    // Operation queue depth, a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now_ms;
        logic              frame_changed;
        logic [CRC_W-1:0]  canvas_crc;
    } ssc_op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ssc_qstat_t;

    typedef struct packed {
        logic [TIME_W-1:0] client_timeout_ms;
        logic [TIME_W-1:0] frame_period_ms;
        logic [LEN_W-1:0]  frame_bytes;
    } ssc_cfg_t;

    typedef struct packed {
        logic [1:0]       event_res;
        logic [SEQ_W-1:0] frame_sequence;
        logic [LEN_W-1:0] payload_length;
        logic [CRC_W-1:0] payload_crc;
    } ssc_res_t;

endpackage

>>> rtl/core/ssc_stream_if.sv
// Valid/ready channel interfaces for input items and result items.
interface ssc_item_if;
    import ssc_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [TIME_W-1:0] now_ms;
    logic              frame_changed;
    logic [CRC_W-1:0]  canvas_crc;

    modport source (output valid, output kind, output data_byte, output now_ms,
                    output frame_changed, output canvas_crc, input ready);
    modport sink (input valid, input kind, input data_byte, input now_ms,
                  input frame_changed, input canvas_crc, output ready);
endinterface

interface ssc_result_if;
    import ssc_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       event_res;
    logic [SEQ_W-1:0] frame_sequence;
    logic [LEN_W-1:0] payload_length;
    logic [CRC_W-1:0] payload_crc;

    modport source (output valid, output event_res, output frame_sequence,
                    output payload_length, output payload_crc, input ready);
    modport sink (input valid, input event_res, input frame_sequence,
                  input payload_length, input payload_crc, output ready);
endinterface

>>> rtl/core/ssc_front.sv
// Front end: accepts items, assembles and matches command lines, issues operations.
module ssc_front (
    input  logic            clk,
    input  logic            rst_n,
    ssc_item_if.sink        item,
    input  ssc_pkg::ssc_qstat_t qstat,
    output logic            push,
    output ssc_pkg::ssc_op_t push_op
);
    import ssc_pkg::*;

    logic [LINE_W-1:0]    line_len_reg, line_len_next;
    logic [CMD_COUNT-1:0] match_reg, match_next;
    logic                 ended_reg, ended_next;
    logic [CMD_COUNT-1:0] len_hit;
    logic [CMD_COUNT-1:0] char_hit;
    logic [CMD_COUNT-1:0] hit;
    logic [CMD_POS_W-1:0] pos;
    logic                 accept;

    assign item.ready = !qstat.full;
    assign accept     = item.valid && item.ready;
    assign pos        = CMD_POS_W'(line_len_reg);

    // Per-command compare of the current position against the table.
    always_comb
    begin
        for (int i = 0; i < CMD_COUNT; i++)
        begin
            len_hit[i]  = (line_len_reg == CMD_LEN[i]);
            char_hit[i] = (line_len_reg < CMD_LEN[i]) && (CMD_TEXT[i][pos] == item.data_byte);
        end
    end

    always_comb
    begin
        line_len_next         = line_len_reg;
        match_next            = match_reg;
        ended_next            = ended_reg;
        push                  = 1'b0;
        push_op.op            = OP_TICK;
        push_op.now_ms        = item.now_ms;
        push_op.frame_changed = item.frame_changed;
        push_op.canvas_crc    = item.canvas_crc;
        hit                   = ended_reg ? match_reg : (match_reg & len_hit);

        if (accept)
        begin
            if (item.kind == KIND_TICK)
            begin
                push = 1'b1;
            end
            else if (item.data_byte == CHAR_CR)
            begin
                // Carriage return leaves the line untouched.
            end
            else if (item.data_byte == CHAR_LF)
            begin
                if (hit[CMD_ON])
                begin
                    push       = 1'b1;
                    push_op.op = OP_ON;
                end
                else if (hit[CMD_PING])
                begin
                    push       = 1'b1;
                    push_op.op = OP_PING;
                end
                else if (hit[CMD_OFF])
                begin
                    push       = 1'b1;
                    push_op.op = OP_OFF;
                end
                line_len_next = '0;
                match_next    = '1;
                ended_next    = 1'b0;
            end
            else if (line_len_reg < LINE_W'(LINE_CAPACITY - 1))
            begin
                if (!ended_reg)
                begin
                    if (item.data_byte == CHAR_NULL)
                    begin
                        match_next = match_reg & len_hit;
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        match_next = match_reg & char_hit;
                    end
                end
                line_len_next = line_len_reg + LINE_W'(1);
            end
            else
            begin
                // Overflow drops the byte and restarts the line.
                line_len_next = '0;
                match_next    = '1;
                ended_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg <= '0;
            match_reg    <= '1;
            ended_reg    <= 1'b0;
        end
        else
        begin
            line_len_reg <= line_len_next;
            match_reg    <= match_next;
            ended_reg    <= ended_next;
        end
    end

endmodule

>>> rtl/core/ssc_queue.sv
// Small operation queue between the front end and the session engine.
module ssc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ssc_pkg::ssc_op_t     push_op,
    input  logic                 pop,
    output ssc_pkg::ssc_op_t     head_op,
    output ssc_pkg::ssc_qstat_t  qstat
);
    import ssc_pkg::*;

    ssc_op_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head_op     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/ssc_back.sv
// Session engine: executes operations, keeps session state, holds the result register.
module ssc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ssc_pkg::ssc_cfg_t   cfg,
    input  ssc_pkg::ssc_op_t    head_op,
    input  ssc_pkg::ssc_qstat_t qstat,
    output logic                pop,
    output logic                res_valid,
    input  logic                res_ready,
    output ssc_pkg::ssc_res_t   res
);
    import ssc_pkg::*;

    logic              stream_reg, stream_next;
    logic              pending_reg, pending_next;
    logic [TIME_W-1:0] client_time_reg, client_time_next;
    logic [TIME_W-1:0] frame_time_reg, frame_time_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              out_valid_reg, out_valid_next;
    ssc_res_t          out_reg, out_next;
    logic [TIME_W-1:0] client_elapsed;
    logic [TIME_W-1:0] frame_elapsed;
    logic              timed_out;
    logic              tick_stream;
    logic              tick_pending;
    logic              emit;

    assign pop       = !qstat.empty && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign client_elapsed = head_op.now_ms - client_time_reg;
    assign frame_elapsed  = head_op.now_ms - frame_time_reg;
    assign timed_out      = stream_reg && (client_elapsed > cfg.client_timeout_ms);
    assign tick_stream    = stream_reg && !timed_out;
    assign tick_pending   = head_op.frame_changed || (pending_reg && !timed_out);

    always_comb
    begin
        stream_next      = stream_reg;
        pending_next     = pending_reg;
        client_time_next = client_time_reg;
        frame_time_next  = frame_time_reg;
        seq_next         = seq_reg;
        emit             = 1'b0;
        out_next         = '0;
        out_valid_next   = out_valid_reg && !res_ready;

        if (pop)
        begin
            case (head_op.op)
                OP_ON:
                begin
                    stream_next        = 1'b1;
                    pending_next       = 1'b1;
                    client_time_next   = head_op.now_ms;
                    emit               = 1'b1;
                    out_next.event_res = EV_READY;
                end
                OP_PING:
                begin
                    if (stream_reg)
                    begin
                        client_time_next = head_op.now_ms;
                    end
                end
                OP_OFF:
                begin
                    stream_next        = 1'b0;
                    pending_next       = 1'b0;
                    emit               = 1'b1;
                    out_next.event_res = EV_STOPPED;
                end
                OP_TICK:
                begin
                    stream_next  = tick_stream;
                    pending_next = tick_pending;
                    if (tick_stream && tick_pending && (frame_elapsed >= cfg.frame_period_ms))
                    begin
                        emit                    = 1'b1;
                        out_next.event_res      = EV_FRAME;
                        out_next.frame_sequence = seq_reg;
                        out_next.payload_length = cfg.frame_bytes;
                        out_next.payload_crc    = head_op.canvas_crc;
                        seq_next                = seq_reg + SEQ_W'(1);
                        pending_next            = 1'b0;
                        frame_time_next         = head_op.now_ms;
                    end
                end
                default:
                begin
                end
            endcase
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_reg      <= 1'b0;
            pending_reg     <= 1'b0;
            client_time_reg <= '0;
            frame_time_reg  <= '0;
            seq_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stream_reg      <= stream_next;
            pending_reg     <= pending_next;
            client_time_reg <= client_time_next;
            frame_time_reg  <= frame_time_next;
            seq_reg         <= seq_next;
            out_valid_reg   <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/stream_session_controller.sv
// Top level of the stream session controller.
//
// The controller takes one transaction per clock cycle on its item channel, sustained
// indefinitely while the result channel keeps taking results; that rate is set by the
// single result register at the back, which is refilled in the same cycle it is emptied.
// A transaction is either a received command byte or an update tick. Command bytes are
// assembled and matched against the ON, PING and OFF commands in the front end, one byte
// per cycle, so nothing about the line costs extra time at the newline. Ticks and decoded
// commands then pass through a two-entry operation queue to the session engine, which
// owns streaming state, the client and frame timers and the frame sequence counter. A
// result, when a transaction produces one, is registered at the back after the transaction
// has passed through the queue and is held there until taken; meanwhile the front end
// keeps accepting until the queue fills. Ready and stopped replies carry zeros in the
// sequence, length and CRC fields. Configuration writes take effect at the writing edge
// and are expected only while no transaction is in flight; unknown indexes are ignored.
// There is no initialization sweep after reset.
module stream_session_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    ssc_item_if.sink                        item,
    ssc_result_if.source                    result,
    input  logic                            cfg_write,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssc_pkg::*;

    ssc_cfg_t   cfg_reg;
    ssc_cfg_t   cfg_next;
    ssc_op_t    push_op;
    ssc_op_t    head_op;
    ssc_qstat_t qstat;
    ssc_res_t   res;
    logic       push;
    logic       pop;

    // Register file: each write to a known index lands in exactly one field, by index.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDX_CLIENT_TIMEOUT: cfg_next.client_timeout_ms = TIME_W'(cfg_data);
                CFG_IDX_FRAME_PERIOD:   cfg_next.frame_period_ms   = TIME_W'(cfg_data);
                CFG_IDX_FRAME_BYTES:    cfg_next.frame_bytes       = cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.client_timeout_ms <= CFG_CLIENT_TIMEOUT_RST;
            cfg_reg.frame_period_ms   <= CFG_FRAME_PERIOD_RST;
            cfg_reg.frame_bytes       <= CFG_FRAME_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: line assembly and command decode.
    ssc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .qstat   (qstat),
        .push    (push),
        .push_op (push_op)
    );

    // Operation queue that decouples decode from execution.
    ssc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .qstat   (qstat)
    );

    // Session engine with its result register.
    ssc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head_op   (head_op),
        .qstat     (qstat),
        .pop       (pop),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res)
    );

    assign result.event_res      = res.event_res;
    assign result.frame_sequence = res.frame_sequence;
    assign result.payload_length = res.payload_length;
    assign result.payload_crc    = res.payload_crc;

endmodule

>>> rtl/core/ssc_checker.sv
// Port-level checker for the stream session controller and its bind.
module ssc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            res_valid,
    input logic                            res_ready,
    input logic [1:0]                      event_res,
    input logic [ssc_pkg::SEQ_W-1:0]       frame_sequence,
    input logic [ssc_pkg::LEN_W-1:0]       payload_length,
    input logic [ssc_pkg::CRC_W-1:0]       payload_crc,
    input logic                            cfg_write,
    input logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ssc_pkg::*;

    logic             seen_frame_reg;
    logic [SEQ_W-1:0] last_seq_reg;
    logic [LEN_W-1:0] frame_bytes_reg;
    logic             frame_taken;

    assign frame_taken = res_valid && res_ready && (event_res == EV_FRAME);

    // Shadow of the payload length register and of the last delivered sequence number.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_frame_reg  <= 1'b0;
            last_seq_reg    <= '0;
            frame_bytes_reg <= CFG_FRAME_BYTES_RST;
        end
        else
        begin
            if (frame_taken)
            begin
                seen_frame_reg <= 1'b1;
                last_seq_reg   <= frame_sequence;
            end
            if (cfg_write && (cfg_index == CFG_IDX_FRAME_BYTES))
            begin
                frame_bytes_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    // A stalled result keeps its contents.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(event_res)
            && $stable(frame_sequence) && $stable(payload_length) && $stable(payload_crc))
        else $error("result changed while stalled");

    // Replies other than frame headers carry zero payload fields.
    a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res != EV_FRAME) |->
            (frame_sequence == '0) && (payload_length == '0) && (payload_crc == '0))
        else $error("reply carries nonzero frame fields");

    // Frame headers are numbered consecutively from zero.
    a_seq_order: assert property (@(posedge clk) disable iff (!rst_n)
        frame_taken |-> (seen_frame_reg ? (frame_sequence == last_seq_reg + SEQ_W'(1))
                                        : (frame_sequence == '0)))
        else $error("frame sequence out of order");

    // Frame headers report the configured payload length.
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (event_res == EV_FRAME) |-> payload_length == frame_bytes_reg)
        else $error("frame header length differs from configuration");

endmodule

bind stream_session_controller ssc_checker u_ssc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .event_res      (result.event_res),
    .frame_sequence (result.frame_sequence),
    .payload_length (result.payload_length),
    .payload_crc    (result.payload_crc),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
);

>>> sim/tb_stream_session_controller.sv
// Self-checking testbench of the stream session controller with its own session predictor.
module tb_stream_session_controller;
    timeunit 1ns;
    timeprecision 1ps;

    import ssc_pkg::*;

    // Timing of the run. The limit is far above the slowest correct run, even with every
    // gap and stall at its longest.
    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_NS     = 2_000_000;

    // Register index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // Command lines as the link sends them: a common ten-byte prefix, then the keyword.
    // This table is kept apart from the package on purpose, so that a wrong entry there
    // shows up as a mismatch instead of being copied into the prediction.
    localparam logic [7:0] SESSION_CMD [3][14] = '{
        '{8'h46, 8'h4D, 8'h4A, 8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h20,
          8'h4F, 8'h4E, 8'h00, 8'h00},
        '{8'h46, 8'h4D, 8'h4A, 8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h20,
          8'h50, 8'h49, 8'h4E, 8'h47},
        '{8'h46, 8'h4D, 8'h4A, 8'h53, 8'h54, 8'h52, 8'h45, 8'h41, 8'h4D, 8'h20,
          8'h4F, 8'h46, 8'h46, 8'h00}
    };
    localparam int SESSION_CMD_LEN [3] = '{12, 14, 13};

    // One input transaction as the testbench builds it.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [TIME_W-1:0] now_ms;
        logic              frame_changed;
        logic [CRC_W-1:0]  canvas_crc;
    } session_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ssc_item_if   item_ch ();
    ssc_result_if result_ch ();

    stream_session_controller i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicted copy of the configuration registers.
    logic [TIME_W-1:0] pred_client_timeout;
    logic [TIME_W-1:0] pred_frame_period;
    logic [LEN_W-1:0]  pred_frame_bytes;

    // Predicted session state.
    logic              pred_streaming;
    logic              pred_frame_pending;
    logic [TIME_W-1:0] pred_client_time;
    logic [TIME_W-1:0] pred_frame_time;
    logic [SEQ_W-1:0]  pred_sequence;
    int                pred_line_length;
    logic [2:0]        pred_match_flags;
    logic              pred_line_ended;

    // Results the block owes us, oldest first.
    ssc_res_t expected_results [$];
    int       mismatch_count = 0;

    // Stimulus state. The millisecond clock is the testbench's notion of "now"; it
    // mostly moves forward in small steps, but jumps and wraps on purpose.
    logic [TIME_W-1:0] clock_ms      = '0;
    int                byte_step_max = 0;
    int                items_sent    = 0;
    int                burst_left    = 0;
    bit                gaps_on       = 1'b1;
    bit                rx_stalls_on  = 1'b1;
    int                rx_hold_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // The whole run ends here if the block stops answering.
    initial begin
        #(LIMIT_NS);
        $display("%0t ns: run did not complete in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic ssc_res_t make_result(input logic [1:0] ev,
                                             input logic [SEQ_W-1:0] seq,
                                             input logic [LEN_W-1:0] len,
                                             input logic [CRC_W-1:0] crc);
        ssc_res_t r;
        r.event_res      = ev;
        r.frame_sequence = seq;
        r.payload_length = len;
        r.payload_crc    = crc;
        return r;
    endfunction

    task automatic restart_line();
        pred_line_length = 0;
        pred_match_flags = '1;
        pred_line_ended  = 1'b0;
    endtask

    task automatic reset_predictor();
        pred_client_timeout = CFG_CLIENT_TIMEOUT_RST;
        pred_frame_period   = CFG_FRAME_PERIOD_RST;
        pred_frame_bytes    = CFG_FRAME_BYTES_RST;
        pred_streaming      = 1'b0;
        pred_frame_pending  = 1'b0;
        pred_client_time    = '0;
        pred_frame_time     = '0;
        pred_sequence       = '0;
        restart_line();
    endtask

    // A received byte either extends the line and narrows the set of commands it can
    // still be, or, on newline, acts on whatever command survived.
    task automatic predict_session_byte(input logic [BYTE_W-1:0] b, input logic [TIME_W-1:0] now);
        logic [2:0] hit;
        int         c;
        if (b == CHAR_LF) begin
            hit = pred_match_flags;
            // Without a zero byte the length still has to be exactly right.
            if (!pred_line_ended) begin
                for (c = 0; c < 3; c++) begin
                    if (pred_line_length != SESSION_CMD_LEN[c])
                        hit[c] = 1'b0;
                end
            end
            if (hit[CMD_ON]) begin
                pred_streaming     = 1'b1;
                pred_frame_pending = 1'b1;
                pred_client_time   = now;
                expected_results.push_back(make_result(EV_READY, '0, '0, '0));
            end
            else if (hit[CMD_PING]) begin
                // A ping only counts while a session is open.
                if (pred_streaming)
                    pred_client_time = now;
            end
            else if (hit[CMD_OFF]) begin
                pred_streaming     = 1'b0;
                pred_frame_pending = 1'b0;
                expected_results.push_back(make_result(EV_STOPPED, '0, '0, '0));
            end
            restart_line();
        end
        else if (b != CHAR_CR) begin
            if (pred_line_length + 1 < LINE_CAPACITY) begin
                if (!pred_line_ended) begin
                    if (b == CHAR_NULL) begin
                        // A zero byte freezes the comparison at the current length.
                        for (c = 0; c < 3; c++) begin
                            if (pred_line_length != SESSION_CMD_LEN[c])
                                pred_match_flags[c] = 1'b0;
                        end
                        pred_line_ended = 1'b1;
                    end
                    else begin
                        for (c = 0; c < 3; c++) begin
                            if (pred_line_length >= SESSION_CMD_LEN[c])
                                pred_match_flags[c] = 1'b0;
                            else if (SESSION_CMD[c][pred_line_length] != b)
                                pred_match_flags[c] = 1'b0;
                        end
                    end
                end
                pred_line_length++;
            end
            else begin
                // The line is full: this byte is lost and the line starts over.
                restart_line();
            end
        end
    endtask

    // A tick first drops a silent client, then records a changed frame, then, while streaming,
    // sends a frame header if one is pending and the frame period has run out.
    task automatic predict_session_tick(input logic [TIME_W-1:0] now, input logic changed,
                                        input logic [CRC_W-1:0] crc);
        logic [TIME_W-1:0] since_client;
        logic [TIME_W-1:0] since_frame;
        since_client = now - pred_client_time;
        since_frame  = now - pred_frame_time;
        if (pred_streaming && since_client > pred_client_timeout) begin
            pred_streaming     = 1'b0;
            pred_frame_pending = 1'b0;
        end
        if (changed)
            pred_frame_pending = 1'b1;
        if (pred_streaming && pred_frame_pending && since_frame >= pred_frame_period) begin
            expected_results.push_back(make_result(EV_FRAME, pred_sequence, pred_frame_bytes,
                                                   crc));
            pred_sequence      = pred_sequence + 1'b1;
            pred_frame_pending = 1'b0;
            pred_frame_time    = now;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driving the item channel
    // ------------------------------------------------------------------------

    // Offers one transaction and waits for the block to take it. While gaps are on, the
    // sender works in bursts: when a burst runs out it drops valid for a random gap, so
    // gaps land on every phase of the line and tick handling.
    task automatic send_item(input session_item_t it);
        int gap;
        if (gaps_on && burst_left <= 0) begin
            @(negedge clk);
            item_ch.valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge clk);
        item_ch.valid         = 1'b1;
        item_ch.kind          = it.kind;
        item_ch.data_byte     = it.data_byte;
        item_ch.now_ms        = it.now_ms;
        item_ch.frame_changed = it.frame_changed;
        item_ch.canvas_crc    = it.canvas_crc;
        do @(posedge clk); while (!item_ch.ready);
        // The transaction was accepted at this edge; fold it into the prediction.
        if (it.kind == KIND_BYTE)
            predict_session_byte(it.data_byte, it.now_ms);
        else
            predict_session_tick(it.now_ms, it.frame_changed, it.canvas_crc);
        if (it.kind != KIND_BYTE || it.data_byte != CHAR_CR)
            items_sent++;
    endtask

    // Fields that a byte transaction does not use still carry random values.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        session_item_t it;
        clock_ms         = clock_ms + $urandom_range(0, byte_step_max);
        it.kind          = KIND_BYTE;
        it.data_byte     = b;
        it.now_ms        = clock_ms;
        it.frame_changed = 1'($urandom_range(0, 1));
        it.canvas_crc    = $urandom;
        send_item(it);
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now, input logic changed,
                             input logic [CRC_W-1:0] crc);
        session_item_t it;
        clock_ms         = now;
        it.kind          = KIND_TICK;
        it.data_byte     = BYTE_W'($urandom);
        it.now_ms        = now;
        it.frame_changed = changed;
        it.canvas_crc    = crc;
        send_item(it);
    endtask

    // Sends the text of one command, with a carriage return slipped in before
    // position cr_pos when that lies within the command (or at its end).
    task automatic send_command_bytes(input int c, input int cr_pos);
        int k;
        for (k = 0; k < SESSION_CMD_LEN[c]; k++) begin
            if (k == cr_pos)
                send_byte(CHAR_CR);
            send_byte(SESSION_CMD[c][k]);
        end
        if (cr_pos == SESSION_CMD_LEN[c])
            send_byte(CHAR_CR);
    endtask

    function automatic logic [BYTE_W-1:0] random_non_newline();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom); while (b == CHAR_LF);
        return b;
    endfunction

    // Most lines are well-formed commands; the rest are the ways a line goes wrong.
    task automatic send_random_line();
        int variant;
        int c;
        int pos;
        int k;
        variant = $urandom_range(0, 9);
        c       = $urandom_range(0, 2);
        pos     = $urandom_range(0, SESSION_CMD_LEN[c] - 1);
        case (variant)
            5: begin
                // Command, zero byte, then trailing text that must not matter.
                send_command_bytes(c, -1);
                send_byte(CHAR_NULL);
                repeat ($urandom_range(0, 10)) send_byte(random_non_newline());
            end
            6: begin
                // One byte replaced by a random one.
                for (k = 0; k < SESSION_CMD_LEN[c]; k++)
                    send_byte((k == pos) ? random_non_newline() : SESSION_CMD[c][k]);
            end
            7: begin
                // One byte short or one byte too long.
                if ($urandom_range(0, 1) == 0) begin
                    for (k = 0; k < SESSION_CMD_LEN[c] - 1; k++)
                        send_byte(SESSION_CMD[c][k]);
                end
                else begin
                    send_command_bytes(c, -1);
                    send_byte(random_non_newline());
                end
            end
            8: begin
                // Overflow: the line restarts, so a command after it may still match.
                repeat ($urandom_range(31, 40)) send_byte(random_non_newline());
                if ($urandom_range(0, 1) == 0)
                    send_command_bytes(c, -1);
            end
            9: begin
                // A zero byte inside the command text.
                for (k = 0; k < SESSION_CMD_LEN[c]; k++)
                    send_byte((k == pos) ? CHAR_NULL : SESSION_CMD[c][k]);
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    send_command_bytes(c, $urandom_range(0, SESSION_CMD_LEN[c]));
                else
                    send_command_bytes(c, -1);
            end
        endcase
        send_byte(CHAR_LF);
    endtask

    // Ticks mostly follow the clock, but some land exactly on the timeout and frame
    // period boundaries and a few jump anywhere in the 32-bit range.
    task automatic send_random_tick(input int step_max);
        logic [TIME_W-1:0] now;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            now = $urandom;
        else if (pick < 6)
            now = pred_client_time + pred_client_timeout + $urandom_range(0, 1);
        else if (pick < 10)
            now = pred_frame_time + pred_frame_period - $urandom_range(0, 1);
        else
            now = clock_ms + $urandom_range(0, step_max);
        send_tick(now, $urandom_range(0, 9) < 7, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------

    // Lets the block run dry. A line byte produces no result, so once the last
    // expected result is in, a drain wait follows before anything is rewritten.
    task automatic wait_until_idle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        case (idx)
            CFG_IDX_CLIENT_TIMEOUT: pred_client_timeout = data;
            CFG_IDX_FRAME_PERIOD:   pred_frame_period   = data;
            CFG_IDX_FRAME_BYTES:    pred_frame_bytes    = data[LEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
        cfg_data  = $urandom;
    endtask

    // Upper bits of the frame length write are random and must be dropped; the
    // unused index gets a random write that must change nothing.
    task automatic configure_session(input logic [TIME_W-1:0] timeout_ms,
                                     input logic [TIME_W-1:0] period_ms,
                                     input logic [LEN_W-1:0] frame_len);
        wait_until_idle();
        write_register(CFG_IDX_CLIENT_TIMEOUT, timeout_ms);
        write_register(CFG_IDX_FRAME_PERIOD, period_ms);
        write_register(CFG_IDX_FRAME_BYTES, {16'($urandom), frame_len});
        write_register(CFG_IDX_UNUSED, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Walks one session by hand at the reset settings: a pending frame before the
    // session opens, ON with a carriage return inside, a tick under and one
    // exactly at the frame period, a client timeout, PING while stopped, and OFF.
    task automatic test_directed_session();
        byte_step_max = 0;
        gaps_on       = 1'b0;
        send_tick(32'd0, 1'b1, 32'h0000_0000);
        send_command_bytes(CMD_ON, 5);
        send_byte(CHAR_LF);
        send_tick(32'd60, 1'b0, 32'hFFFF_FFFF);
        send_tick(32'd100, 1'b0, 32'hFFFF_FFFF);
        send_tick(32'd150, 1'b1, 32'h5A5A_A5A5);
        send_tick(32'd3001, 1'b0, 32'h1234_5678);
        send_command_bytes(CMD_PING, -1);
        send_byte(CHAR_LF);
        send_tick(32'hFFFF_FFFF, 1'b1, 32'h8000_0001);
        send_command_bytes(CMD_OFF, -1);
        send_byte(CHAR_LF);
        gaps_on = 1'b1;
    endtask

    // Every tick emits a frame here, and the receiver holds off long enough for the
    // operation queue and the result register to fill and stall the item channel.
    task automatic test_backpressure();
        configure_session('1, '0, 16'h1234);
        gaps_on      = 1'b0;
        rx_stalls_on = 1'b0;
        send_command_bytes(CMD_ON, -1);
        send_byte(CHAR_LF);
        rx_hold_cycles = 120;
        repeat (40) send_tick(clock_ms + 1, 1'b1, $urandom);
        gaps_on      = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Random traffic until count counted transactions have gone in. Sender gaps and
    // receiver stalls switch on and off now and then, leaving stretches at full rate.
    task automatic run_random_traffic(input int count, input int step_max);
        int start;
        int pick;
        start         = items_sent;
        byte_step_max = 1;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_random_line();
            else if (pick < 24)
                send_byte(BYTE_W'($urandom));
            else
                send_random_tick(step_max);
            if ($urandom_range(0, 49) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 49) == 0)
                rx_stalls_on = !rx_stalls_on;
        end
    endtask

    // Zero timeout and period, then both at their maximum, with the frame length at
    // both of its extremes.
    task automatic test_register_extremes();
        configure_session('0, '0, '0);
        run_random_traffic(250, 1);
        configure_session('1, '1, '1);
        run_random_traffic(200, 30);
    endtask

    // Ordinary sessions under a spread of settings, ending back at the reset values.
    task automatic test_random_sessions();
        configure_session(32'd500, 32'd20, LEN_W'($urandom));
        run_random_traffic(300, 10);
        configure_session($urandom_range(50, 3000), $urandom_range(0, 60), LEN_W'($urandom));
        run_random_traffic(350, 25);
        configure_session(32'd200, 32'd5, LEN_W'($urandom));
        run_random_traffic(300, 20);
        configure_session(CFG_CLIENT_TIMEOUT_RST, CFG_FRAME_PERIOD_RST, CFG_FRAME_BYTES_RST);
        run_random_traffic(150, 40);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // The receiver stalls on a pattern of its own: runs of ready and of stall with
    // random lengths. A hold-off request from a test overrides it for that many cycles.
    initial begin
        int   run_left;
        logic ready_level;
        run_left        = 0;
        ready_level     = 1'b1;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                result_ch.ready = 1'b0;
                rx_hold_cycles--;
            end
            else if (!rx_stalls_on) begin
                result_ch.ready = 1'b1;
            end
            else begin
                if (run_left == 0) begin
                    ready_level = ($urandom_range(0, 9) < 7);
                    run_left    = ready_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
                end
                run_left--;
                result_ch.ready = ready_level;
            end
        end
    end

    task automatic check_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, field_name, want, got);
            mismatch_count++;
        end
    endtask

    // Every transaction taken on the result channel is compared with the oldest
    // expected result.
    initial begin
        ssc_res_t want;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result with event 0x%0h arrived with none expected",
                             $time, result_ch.event_res);
                    mismatch_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("event_res", 32'(want.event_res), 32'(result_ch.event_res));
                    check_field("frame_sequence", 32'(want.frame_sequence),
                                32'(result_ch.frame_sequence));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(result_ch.payload_length));
                    check_field("payload_crc", want.payload_crc, result_ch.payload_crc);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = CFG_IDX_CLIENT_TIMEOUT;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.kind          = KIND_BYTE;
        item_ch.data_byte     = '0;
        item_ch.now_ms        = '0;
        item_ch.frame_changed = 1'b0;
        item_ch.canvas_crc    = '0;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_session();
        test_backpressure();
        test_register_extremes();
        test_random_sessions();

        // Let every owed result come out, then give the block a little longer to
        // show any result it should not have produced.
        wait_until_idle();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
